// File: rtl/char_lcd_write_sequencer_defines.svh
// Assertion macros used by the microcode sequencer (clsq_useq) of the character LCD write sequencer RTL.
`ifndef CHAR_LCD_WRITE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_WRITE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define CLSQ_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define CLSQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/clsq_pkg.sv
// Types, codes and microprogram store of the character LCD write sequencer.
`timescale 1ns / 1ps
`default_nettype none

package clsq_pkg;

  // Request kinds
  localparam logic [2:0] KIND_INIT  = 3'd0;
  localparam logic [2:0] KIND_POS   = 3'd1;
  localparam logic [2:0] KIND_CHAR  = 3'd2;
  localparam logic [2:0] KIND_INT   = 3'd3;
  localparam logic [2:0] KIND_CLEAR = 3'd4;

  // LCD command bytes
  localparam logic [7:0] CMD_FUNC_4BIT  = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h0F;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] ROW1_BASE      = 8'h40;
  localparam logic [7:0] CMD_DDRAM      = 8'h80;
  localparam logic [7:0] WAKE_8BIT      = 8'h30;
  localparam logic [7:0] CMD_FUNC_8BIT  = 8'h38;
  localparam logic [7:0] WAKE_4BIT      = 8'h03;
  localparam logic [7:0] FUNC_NIBBLE    = 8'h02;
  localparam logic [7:0] CHAR_MINUS     = 8'h2D;
  localparam logic [3:0] CHAR_DIGIT_HI  = 4'h3;

  // Waits in microseconds
  localparam logic [14:0] W_POWER = 15'd18001;
  localparam logic [14:0] W_WAKE1 = 15'd5000;
  localparam logic [14:0] W_WAKE2 = 15'd100;
  localparam logic [14:0] W_WAKE3 = 15'd45;
  localparam logic [14:0] W_BYTE  = 15'd43;
  localparam logic [14:0] W_CLEAR = 15'd2043;
  localparam logic [14:0] W_NONE  = 15'd0;

  // Microprogram entry points
  localparam logic [4:0] PC_INIT      = 5'd0;
  localparam logic [4:0] PC_INIT8     = 5'd6;
  localparam logic [4:0] PC_INIT_TAIL = 5'd10;
  localparam logic [4:0] PC_POS       = 5'd12;
  localparam logic [4:0] PC_CHAR      = 5'd13;
  localparam logic [4:0] PC_CLEAR     = 5'd14;
  localparam logic [4:0] PC_INT       = 5'd15;
  localparam logic [4:0] PC_DIGITS    = 5'd17;

  typedef enum logic [2:0] {
    OP_WAIT,   // pure wait, no strobe
    OP_RAW,    // one strobe with the literal, never split
    OP_BYTE,   // a byte, split into nibbles on a 4-bit bus
    OP_SYNC,   // hold until the decimal converter is done
    OP_DIGIT   // one decimal digit byte per pass, repeats
  } uop_t;

  typedef enum logic [1:0] {
    NX_INC,      // fall through
    NX_GOTO,     // jump to target
    NX_IF_8BIT,  // jump when on the 8-bit bus
    NX_IF_POS    // jump when the integer is not negative
  } unext_t;

  typedef enum logic {
    SRC_LIT,
    SRC_ARG
  } usrc_t;

  typedef struct packed {
    uop_t        op;
    usrc_t       src;
    logic        rs;
    logic [7:0]  lit;
    logic [14:0] wait_us;
    logic        last;
    logic        fin;
    unext_t      nx;
    logic [4:0]  tgt;
  } ucode_t;

  // One result item
  typedef struct packed {
    logic        is_strobe;
    logic        reg_select;
    logic [7:0]  bus_value;
    logic [14:0] wait_us;
    logic        last;
  } lcd_res_t;

  // Start command from the front end to the sequencer
  typedef struct packed {
    logic       start;
    logic [4:0] pc;
    logic [7:0] arg;
  } seq_cmd_t;

  // Decimal converter status
  typedef struct packed {
    logic       busy;
    logic       neg;
    logic [3:0] msd;
  } dec_stat_t;

  function automatic ucode_t uw(uop_t op, usrc_t src, logic rs, logic [7:0] lit,
                                logic [14:0] w, logic last, logic fin, unext_t nx,
                                logic [4:0] tgt);
    ucode_t u;
    u.op      = op;
    u.src     = src;
    u.rs      = rs;
    u.lit     = lit;
    u.wait_us = w;
    u.last    = last;
    u.fin     = fin;
    u.nx      = nx;
    u.tgt     = tgt;
    return u;
  endfunction

  // Microprogram store
  function automatic ucode_t ucode_rom(logic [4:0] pc);
    ucode_t u;
    unique case (pc)
      5'd0:  u = uw(OP_WAIT, SRC_LIT, 1'b0, 8'h00, W_POWER, 1'b0, 1'b0, NX_IF_8BIT,
                    PC_INIT8);
      5'd1:  u = uw(OP_RAW, SRC_LIT, 1'b0, WAKE_4BIT, W_WAKE1, 1'b0, 1'b0, NX_INC, 5'd0);
      5'd2:  u = uw(OP_RAW, SRC_LIT, 1'b0, WAKE_4BIT, W_WAKE2, 1'b0, 1'b0, NX_INC, 5'd0);
      5'd3:  u = uw(OP_RAW, SRC_LIT, 1'b0, WAKE_4BIT, W_WAKE3, 1'b0, 1'b0, NX_INC, 5'd0);
      5'd4:  u = uw(OP_RAW, SRC_LIT, 1'b0, FUNC_NIBBLE, W_WAKE3, 1'b0, 1'b0, NX_INC,
                    5'd0);
      5'd5:  u = uw(OP_BYTE, SRC_LIT, 1'b0, CMD_FUNC_4BIT, W_BYTE, 1'b0, 1'b0, NX_GOTO,
                    PC_INIT_TAIL);
      5'd6:  u = uw(OP_RAW, SRC_LIT, 1'b0, WAKE_8BIT, W_WAKE1, 1'b0, 1'b0, NX_INC, 5'd0);
      5'd7:  u = uw(OP_RAW, SRC_LIT, 1'b0, WAKE_8BIT, W_WAKE2, 1'b0, 1'b0, NX_INC, 5'd0);
      5'd8:  u = uw(OP_RAW, SRC_LIT, 1'b0, WAKE_8BIT, W_WAKE3, 1'b0, 1'b0, NX_INC, 5'd0);
      5'd9:  u = uw(OP_RAW, SRC_LIT, 1'b0, CMD_FUNC_8BIT, W_WAKE3, 1'b0, 1'b0, NX_INC,
                    5'd0);
      5'd10: u = uw(OP_BYTE, SRC_LIT, 1'b0, CMD_DISPLAY_ON, W_BYTE, 1'b0, 1'b0, NX_INC,
                    5'd0);
      5'd11: u = uw(OP_BYTE, SRC_LIT, 1'b0, CMD_CLEAR, W_CLEAR, 1'b1, 1'b1, NX_INC, 5'd0);
      5'd12: u = uw(OP_BYTE, SRC_ARG, 1'b0, 8'h00, W_BYTE, 1'b1, 1'b1, NX_INC, 5'd0);
      5'd13: u = uw(OP_BYTE, SRC_ARG, 1'b1, 8'h00, W_BYTE, 1'b1, 1'b1, NX_INC, 5'd0);
      5'd14: u = uw(OP_BYTE, SRC_LIT, 1'b0, CMD_CLEAR, W_CLEAR, 1'b1, 1'b1, NX_INC, 5'd0);
      5'd15: u = uw(OP_SYNC, SRC_LIT, 1'b0, 8'h00, W_NONE, 1'b0, 1'b0, NX_IF_POS,
                    PC_DIGITS);
      5'd16: u = uw(OP_BYTE, SRC_LIT, 1'b1, CHAR_MINUS, W_BYTE, 1'b0, 1'b0, NX_INC, 5'd0);
      5'd17: u = uw(OP_DIGIT, SRC_LIT, 1'b1, 8'h00, W_BYTE, 1'b0, 1'b1, NX_INC, 5'd0);
      default: u = uw(OP_WAIT, SRC_LIT, 1'b0, 8'h00, W_NONE, 1'b1, 1'b1, NX_INC, 5'd0);
    endcase
    return u;
  endfunction

  // Entry point for each request kind
  function automatic logic [4:0] start_pc(logic [2:0] kind);
    logic [4:0] pc;
    unique case (kind)
      KIND_INIT:  pc = PC_INIT;
      KIND_POS:   pc = PC_POS;
      KIND_CHAR:  pc = PC_CHAR;
      KIND_INT:   pc = PC_INT;
      KIND_CLEAR: pc = PC_CLEAR;
      default:    pc = PC_INIT;
    endcase
    return pc;
  endfunction

endpackage

`default_nettype wire

// File: rtl/clsq_ifs.sv
// Valid/ready channel interfaces for requests and bus results.
`timescale 1ns / 1ps
`default_nettype none

interface clsq_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [7:0]         row;
  logic [7:0]         column;
  logic [7:0]         character;
  logic signed [31:0] int_value;

  modport source (output valid, kind, row, column, character, int_value, input ready);
  modport sink   (input valid, kind, row, column, character, int_value, output ready);
endinterface

interface clsq_res_if;
  logic        valid;
  logic        ready;
  logic        is_strobe;
  logic        reg_select;
  logic [7:0]  bus_value;
  logic [14:0] wait_us;
  logic        last;

  modport source (output valid, is_strobe, reg_select, bus_value, wait_us, last,
                  input ready);
  modport sink   (input valid, is_strobe, reg_select, bus_value, wait_us, last,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/char_lcd_write_sequencer.sv
// Top level: request front end, mode register and result output register.
//
//   channel  role      handshake     payload
//   req      sink      valid/ready   kind, row, column, character, int_value
//   res      source    valid/ready   is_strobe, reg_select, bus_value, wait_us, last
//   cfg      write     cfg_wr_en     cfg_wr_data (bus_four_bit)
//
// One result per cycle while res is ready and no converter sync is pending; a byte
// on the 4-bit bus takes two results. Write integer first runs the shift-per-bit
// decimal converter. req is ready whenever the microcode sequencer is idle, even
// while the last result still waits in the output register. A stalled res holds
// its word. rst is synchronous; it selects the 4-bit bus and idles the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_write_sequencer
  import clsq_pkg::*;
#(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  clsq_req_if.sink          req,
  clsq_res_if.source        res
);

  logic       four_bit;
  logic       seq_busy;
  logic       req_fire;
  logic       req_ok;
  logic [7:0] pos_addr;
  seq_cmd_t   cmd;
  dec_stat_t  dec_stat;
  logic [3:0] dig_sel;
  logic [3:0] digit;
  logic       emit_valid;
  logic       emit_ready;
  lcd_res_t   emit;
  logic       out_valid;
  lcd_res_t   out_word;

  // bus width register
  always_ff @(posedge clk) begin
    if (rst) begin
      four_bit <= 1'b1;
    end else if (cfg_wr_en) begin
      four_bit <= cfg_wr_data;
    end
  end

  // request filter: requests that produce nothing are taken and dropped
  assign req.ready = !seq_busy;
  assign req_fire  = req.valid && req.ready;
  assign pos_addr  = (req.row == 8'd0) ? req.column : ROW1_BASE + req.column;

  always_comb begin
    unique case (req.kind)
      KIND_INIT:  req_ok = 1'b1;
      KIND_POS:   req_ok = (req.row < 8'(ROWS)) && (req.column < 8'(COLUMNS));
      KIND_CHAR:  req_ok = (req.character != 8'd0);
      KIND_INT:   req_ok = 1'b1;
      KIND_CLEAR: req_ok = 1'b1;
      default:    req_ok = 1'b0;
    endcase
  end

  assign cmd.start = req_fire && req_ok;
  assign cmd.pc    = start_pc(req.kind);
  assign cmd.arg   = (req.kind == KIND_POS) ? (CMD_DDRAM | pos_addr) : req.character;

  clsq_dec u_dec (
    .clk   (clk),
    .rst   (rst),
    .start (req_fire && req.kind == KIND_INT),
    .value (req.int_value),
    .sel   (dig_sel),
    .digit (digit),
    .stat  (dec_stat)
  );

  clsq_useq u_seq (
    .clk        (clk),
    .rst        (rst),
    .four_bit   (four_bit),
    .cmd        (cmd),
    .dec        (dec_stat),
    .digit      (digit),
    .dig_sel    (dig_sel),
    .busy       (seq_busy),
    .emit_valid (emit_valid),
    .emit_ready (emit_ready),
    .emit       (emit)
  );

  // output register
  assign emit_ready = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_valid && emit_ready) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid && emit_ready) begin
      out_word <= emit;
    end
  end

  assign res.valid      = out_valid;
  assign res.is_strobe  = out_word.is_strobe;
  assign res.reg_select = out_word.reg_select;
  assign res.bus_value  = out_word.bus_value;
  assign res.wait_us    = out_word.wait_us;
  assign res.last       = out_word.last;

endmodule

`default_nettype wire

// File: rtl/clsq_dec.sv
// Binary to decimal converter: one double-dabble shift per cycle.
`timescale 1ns / 1ps
`default_nettype none

module clsq_dec
  import clsq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] value,
  input  logic [3:0]         sel,
  output logic [3:0]         digit,
  output dec_stat_t          stat
);

  logic        busy;
  logic [5:0]  cnt;
  logic        neg;
  logic [31:0] bin;
  logic [39:0] bcd;
  logic [39:0] bcd_adj;
  logic [3:0]  msd;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < 10; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3
                                                  : bcd[i*4 +: 4];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd32;
    end else if (busy) begin
      cnt  <= cnt - 6'd1;
      busy <= (cnt != 6'd1);
    end
  end

  // shift datapath
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= value[31];
      bin <= value[31] ? (~value + 32'sd1) : value;
      bcd <= '0;
    end else if (busy) begin
      {bcd, bin} <= {bcd_adj[38:0], bin, 1'b0};
    end
  end

  // most significant nonzero digit, zero shows as one digit
  always_comb begin
    msd = '0;
    for (int i = 1; i < 10; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) msd = 4'(i);
    end
  end

  assign digit     = bcd[{sel, 2'b00} +: 4];
  assign stat.busy = busy;
  assign stat.neg  = neg;
  assign stat.msd  = msd;

endmodule

`default_nettype wire

// File: rtl/clsq_useq.sv
// Microcoded sequencer and byte/nibble datapath that emits LCD bus results.
`timescale 1ns / 1ps
`default_nettype none

`include "char_lcd_write_sequencer_defines.svh"

module clsq_useq
  import clsq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      four_bit,
  input  seq_cmd_t  cmd,
  input  dec_stat_t dec,
  input  logic [3:0] digit,
  output logic [3:0] dig_sel,
  output logic      busy,
  output logic      emit_valid,
  input  logic      emit_ready,
  output lcd_res_t  emit
);

  logic       running;
  logic [4:0] pc;
  logic       phase;
  logic [3:0] dig_idx;
  logic [7:0] arg;

  ucode_t     u;
  logic [7:0] byte_val;
  logic       split;
  logic       first_half;
  logic       last_word;
  logic       emit_fire;
  logic       step_done;
  logic       sync_done;
  logic       advance;
  logic       take;
  logic       stay;
  logic [4:0] pc_next;

  assign u = ucode_rom(pc);

  // byte source select
  always_comb begin
    if (u.op == OP_DIGIT) begin
      byte_val = {CHAR_DIGIT_HI, digit};
    end else if (u.src == SRC_ARG) begin
      byte_val = arg;
    end else begin
      byte_val = u.lit;
    end
  end

  assign split      = four_bit && (u.op == OP_BYTE || u.op == OP_DIGIT);
  assign first_half = split && !phase;
  assign last_word  = (u.op == OP_DIGIT) ? (dig_idx == 4'd0) : u.last;

  // result word
  always_comb begin
    emit.is_strobe  = (u.op != OP_WAIT);
    emit.reg_select = u.rs;
    if (split) begin
      emit.bus_value = phase ? {4'h0, byte_val[3:0]} : {4'h0, byte_val[7:4]};
    end else begin
      emit.bus_value = byte_val;
    end
    emit.wait_us = first_half ? W_NONE : u.wait_us;
    emit.last    = first_half ? 1'b0 : last_word;
  end

  assign emit_valid = running && (u.op != OP_SYNC);
  assign emit_fire  = emit_valid && emit_ready;
  assign step_done  = emit_fire && !first_half;
  assign sync_done  = running && (u.op == OP_SYNC) && !dec.busy;
  assign advance    = step_done || sync_done;
  assign stay       = (u.op == OP_DIGIT) && (dig_idx != 4'd0);

  // next step: branch conditions
  always_comb begin
    unique case (u.nx)
      NX_GOTO:    take = 1'b1;
      NX_IF_8BIT: take = !four_bit;
      NX_IF_POS:  take = !dec.neg;
      default:    take = 1'b0;
    endcase
    pc_next = take ? u.tgt : pc + 5'd1;
  end

  // step counter and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      pc      <= PC_INIT;
      phase   <= 1'b0;
      dig_idx <= '0;
    end else if (cmd.start && !running) begin
      running <= 1'b1;
      pc      <= cmd.pc;
      phase   <= 1'b0;
    end else begin
      if (emit_fire && first_half) begin
        phase <= 1'b1;
      end
      if (advance) begin
        phase <= 1'b0;
        if (sync_done) begin
          dig_idx <= dec.msd;
        end
        if (stay) begin
          dig_idx <= dig_idx - 4'd1;
        end else if (u.fin) begin
          running <= 1'b0;
        end else begin
          pc <= pc_next;
        end
      end
    end
  end

  // request argument (position command or character)
  always_ff @(posedge clk) begin
    if (cmd.start && !running) begin
      arg <= cmd.arg;
    end
  end

  assign dig_sel = dig_idx;
  assign busy    = running;

  `CLSQ_ASSERT_HOLDS(a_phase_running, phase, running, "nibble phase set while idle")
  `CLSQ_ASSERT_HOLDS(a_sync_no_phase, running && u.op == OP_SYNC, !phase,
                     "nibble phase pending at converter sync")
  `CLSQ_ASSERT_NEXT(a_last_ends, emit_fire && emit.last, !running,
                    "sequencer still running after final transfer")

endmodule

`default_nettype wire

// File: test/lcd_bus_checker.sv
// Checker for the LCD write sequencer: predicts each request's bus words and compares them.
`timescale 1ns / 1ps

module lcd_bus_checker
  import clsq_pkg::*;
#(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  clsq_req_if  req,
  clsq_res_if  res,
  output int   mismatches,
  output int   outstanding,
  output int   words_checked
);

  localparam int         REPORT_LIMIT = 10;
  localparam logic [7:0] DIGIT_ZERO   = 8'h30;

  // Local copy of the bus width register and the words still due on res
  logic     four_bit_bus;
  lcd_res_t bus_words_q[$];

  task automatic push_word(input logic strobe, input logic rs, input logic [7:0] val,
                           input logic [14:0] wait_us);
    lcd_res_t w;
    w.is_strobe  = strobe;
    w.reg_select = rs;
    w.bus_value  = val;
    w.wait_us    = wait_us;
    w.last       = 1'b0;
    bus_words_q.push_back(w);
  endtask

  // A byte is two strobes on the 4-bit bus, high nibble first, no wait between
  task automatic push_byte(input logic rs, input logic [7:0] b, input logic [14:0] wait_us);
    if (four_bit_bus) begin
      push_word(1'b1, rs, {4'h0, b[7:4]}, 15'd0);
      push_word(1'b1, rs, {4'h0, b[3:0]}, wait_us);
    end else begin
      push_word(1'b1, rs, b, wait_us);
    end
  endtask

  // Expand one request into the bus words it should produce
  task automatic expand_request(input logic [2:0] kind, input logic [7:0] row,
                                input logic [7:0] column, input logic [7:0] character,
                                input logic [31:0] value);
    logic [31:0] mag;
    logic [7:0]  digit_chr[10];
    int          nd;
    int          first;
    first = bus_words_q.size();
    nd = 0;
    case (kind)
      KIND_INIT: begin
        push_word(1'b0, 1'b0, 8'h00, W_POWER);
        if (four_bit_bus) begin
          push_word(1'b1, 1'b0, WAKE_4BIT, W_WAKE1);
          push_word(1'b1, 1'b0, WAKE_4BIT, W_WAKE2);
          push_word(1'b1, 1'b0, WAKE_4BIT, W_WAKE3);
          push_word(1'b1, 1'b0, FUNC_NIBBLE, W_WAKE3);
          push_byte(1'b0, CMD_FUNC_4BIT, W_BYTE);
        end else begin
          push_word(1'b1, 1'b0, WAKE_8BIT, W_WAKE1);
          push_word(1'b1, 1'b0, WAKE_8BIT, W_WAKE2);
          push_word(1'b1, 1'b0, WAKE_8BIT, W_WAKE3);
          push_word(1'b1, 1'b0, CMD_FUNC_8BIT, W_WAKE3);
        end
        push_byte(1'b0, CMD_DISPLAY_ON, W_BYTE);
        push_byte(1'b0, CMD_CLEAR, W_CLEAR);
      end
      KIND_POS: begin
        // out-of-range row or column sends nothing
        if (row < ROWS && column < COLUMNS)
          push_byte(1'b0, CMD_DDRAM | ((row == 8'd0) ? column : ROW1_BASE + column), W_BYTE);
      end
      KIND_CHAR: begin
        if (character != 8'h00)
          push_byte(1'b1, character, W_BYTE);
      end
      KIND_INT: begin
        // magnitude in unsigned terms so the most negative value works too
        mag = value[31] ? (~value + 32'd1) : value;
        do begin
          digit_chr[nd] = DIGIT_ZERO + 8'(mag % 32'd10);
          nd++;
          mag = mag / 32'd10;
        end while (mag != 32'd0 && nd < 10);
        if (value[31])
          push_byte(1'b1, CHAR_MINUS, W_BYTE);
        for (int i = nd - 1; i >= 0; i--)
          push_byte(1'b1, digit_chr[i], W_BYTE);
      end
      KIND_CLEAR: push_byte(1'b0, CMD_CLEAR, W_CLEAR);
      default: ;
    endcase
    if (bus_words_q.size() > first)
      bus_words_q[bus_words_q.size() - 1].last = 1'b1;
  endtask

  // Compare outgoing words first, then queue predictions for a new request
  always @(posedge clk) begin
    lcd_res_t want;
    logic     bad;
    if (rst) begin
      four_bit_bus = 1'b1;
      bus_words_q.delete();
      mismatches    = 0;
      outstanding   = 0;
      words_checked = 0;
    end else begin
      if (cfg_wr_en)
        four_bit_bus = cfg_wr_data;
      if (res.valid && res.ready) begin
        words_checked++;
        if (bus_words_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: unexpected bus word strobe=%0b rs=%0b bus=%02h wait=%0d last=%0b",
                     $time, res.is_strobe, res.reg_select, res.bus_value, res.wait_us,
                     res.last);
        end else begin
          want = bus_words_q.pop_front();
          bad = (want.is_strobe  !== res.is_strobe)  ||
                (want.reg_select !== res.reg_select) ||
                (want.bus_value  !== res.bus_value)  ||
                (want.wait_us    !== res.wait_us)    ||
                (want.last       !== res.last);
          if (bad) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: bus word %0d expected strobe=%0b rs=%0b bus=%02h wait=%0d last=%0b",
                       $time, words_checked, want.is_strobe, want.reg_select, want.bus_value,
                       want.wait_us, want.last);
              $display("%0t: bus word %0d actual   strobe=%0b rs=%0b bus=%02h wait=%0d last=%0b",
                       $time, words_checked, res.is_strobe, res.reg_select, res.bus_value,
                       res.wait_us, res.last);
            end
          end
        end
      end
      if (req.valid && req.ready)
        expand_request(req.kind, req.row, req.column, req.character, req.int_value);
      outstanding = bus_words_q.size();
    end
  end

endmodule

// File: test/tb_top.sv
// Testbench top for the LCD write sequencer: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import clsq_pkg::*;

  localparam int                 COLUMNS          = 16;
  localparam int                 ROWS             = 2;
  localparam logic [2:0]         KIND_SPARE_LO    = 3'd5;
  localparam logic [2:0]         KIND_SPARE_HI    = 3'd7;
  localparam logic signed [31:0] INT_MIN_VAL      = 32'sh8000_0000;
  localparam logic signed [31:0] INT_MAX_VAL      = 32'sh7FFF_FFFF;
  localparam int                 IDLE_PCT         = 34;
  localparam int                 SETTLE_CYCLES    = 64;
  localparam int                 QUIET_LIMIT      = 2000;
  localparam int                 RANDOM_PER_PHASE = 54;

  typedef struct {
    logic [2:0]         kind;
    logic [7:0]         row;
    logic [7:0]         column;
    logic [7:0]         character;
    logic signed [31:0] int_value;
  } lcd_request_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;
  bit   steady;
  bit   timed_out;
  int   requests_sent;
  int   productive_sent;
  int   mode_writes;
  int   mismatches;
  int   outstanding;
  int   words_checked;

  clsq_req_if req_ch();
  clsq_res_if res_ch();

  char_lcd_write_sequencer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_ch),
    .res        (res_ch)
  );

  lcd_bus_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) i_bus_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .req          (req_ch),
    .res          (res_ch),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .words_checked(words_checked)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls at random except during a steady stretch
  always @(negedge clk) begin
    res_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  function automatic lcd_request_t make_request(input logic [2:0] kind, input logic [7:0] row,
                                                input logic [7:0] column,
                                                input logic [7:0] character,
                                                input logic signed [31:0] value);
    lcd_request_t r;
    r.kind      = kind;
    r.row       = row;
    r.column    = column;
    r.character = character;
    r.int_value = value;
    return r;
  endfunction

  // True when the request should put something on the bus
  function automatic bit makes_output(input lcd_request_t r);
    case (r.kind)
      KIND_INIT, KIND_INT, KIND_CLEAR: return 1'b1;
      KIND_POS:  return (r.row < ROWS) && (r.column < COLUMNS);
      KIND_CHAR: return r.character != 8'h00;
      default:   return 1'b0;
    endcase
  endfunction

  // Mostly well-formed requests with random content, some noise
  function automatic lcd_request_t random_request();
    lcd_request_t r;
    int           pick;
    r.kind      = KIND_INIT;
    r.row       = 8'($urandom);
    r.column    = 8'($urandom);
    r.character = 8'($urandom);
    r.int_value = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      r.kind = KIND_INIT;
    end else if (pick < 24) begin
      r.kind = KIND_POS;
      if ($urandom_range(0, 4) != 0) begin
        r.row    = 8'($urandom_range(0, ROWS - 1));
        r.column = 8'($urandom_range(0, COLUMNS - 1));
      end
    end else if (pick < 48) begin
      r.kind = KIND_CHAR;
      if ($urandom_range(0, 9) == 0)
        r.character = 8'h00;
    end else if (pick < 82) begin
      r.kind = KIND_INT;
      case ($urandom_range(0, 3))
        0: r.int_value = $urandom_range(0, 99);
        1: r.int_value = $urandom_range(0, 99999);
        2: r.int_value = $urandom_range(0, 1) ? INT_MIN_VAL : INT_MAX_VAL;
        default: ;
      endcase
      if ($urandom_range(0, 3) == 0)
        r.int_value = -r.int_value;
    end else if (pick < 92) begin
      r.kind = KIND_CLEAR;
    end else begin
      r.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    end
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_request(input lcd_request_t r);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid     = 1'b1;
    req_ch.kind      = r.kind;
    req_ch.row       = r.row;
    req_ch.column    = r.column;
    req_ch.character = r.character;
    req_ch.int_value = r.int_value;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    requests_sent++;
    if (makes_output(r))
      productive_sent++;
  endtask

  // Hold requests until every expected word is out, then let the converter finish
  task automatic drain_and_settle();
    req_ch.valid = 1'b0;
    while (outstanding != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_bus_mode(input logic four_bit);
    drain_and_settle();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = four_bit;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    mode_writes++;
  endtask

  // Random requests until count of them produced output
  task automatic random_phase(input int count, input int steady_items, input int pause_at);
    lcd_request_t r;
    int           done;
    done = 0;
    while (done < count) begin
      r = random_request();
      steady = (done < steady_items);
      send_request(r);
      if (makes_output(r)) begin
        done++;
        if (done == pause_at)
          drain_and_settle();
      end
    end
    steady = 1'b0;
  endtask

  task automatic run_stimulus();
    rst = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed, 4-bit bus from reset
    send_request(make_request(KIND_INIT, 8'd0, 8'd0, 8'h00, 32'sd0));
    send_request(make_request(KIND_POS, 8'd0, 8'd0, 8'h00, 32'sd0));
    send_request(make_request(KIND_POS, 8'd1, 8'd15, 8'h00, 32'sd0));
    send_request(make_request(KIND_POS, 8'd2, 8'd0, 8'h00, 32'sd0));
    send_request(make_request(KIND_POS, 8'd0, 8'd16, 8'h00, 32'sd0));
    send_request(make_request(KIND_POS, 8'd255, 8'd255, 8'hFF, 32'sd0));
    send_request(make_request(KIND_CHAR, 8'd0, 8'd0, 8'h00, 32'sd0));
    send_request(make_request(KIND_CHAR, 8'd0, 8'd0, 8'hFF, 32'sd0));
    send_request(make_request(KIND_CHAR, 8'd0, 8'd0, 8'h41, 32'sd0));
    send_request(make_request(KIND_INT, 8'd0, 8'd0, 8'h00, 32'sd0));
    send_request(make_request(KIND_INT, 8'd0, 8'd0, 8'h00, -32'sd1));
    send_request(make_request(KIND_INT, 8'd0, 8'd0, 8'h00, INT_MAX_VAL));
    send_request(make_request(KIND_INT, 8'd0, 8'd0, 8'h00, INT_MIN_VAL));
    send_request(make_request(KIND_CLEAR, 8'd0, 8'd0, 8'h00, 32'sd0));
    send_request(make_request(KIND_SPARE_LO, 8'd0, 8'd0, 8'h00, 32'sd0));

    // Directed, 8-bit bus
    write_bus_mode(1'b0);
    send_request(make_request(KIND_INIT, 8'd0, 8'd0, 8'h00, 32'sd0));
    send_request(make_request(KIND_POS, 8'd1, 8'd0, 8'h00, 32'sd0));
    send_request(make_request(KIND_CHAR, 8'd0, 8'd0, 8'h80, 32'sd0));
    send_request(make_request(KIND_INT, 8'd0, 8'd0, 8'h00, INT_MIN_VAL));
    send_request(make_request(KIND_INT, 8'd0, 8'd0, 8'h00, 32'sd1000000000));
    send_request(make_request(KIND_CLEAR, 8'd0, 8'd0, 8'h00, 32'sd0));
    send_request(make_request(KIND_SPARE_HI, 8'd0, 8'd0, 8'h00, 32'sd0));

    // Random phases over both bus widths
    write_bus_mode(1'b1);
    random_phase(RANDOM_PER_PHASE, 0, RANDOM_PER_PHASE / 2);
    write_bus_mode(1'b0);
    random_phase(RANDOM_PER_PHASE, 30, 0);
    write_bus_mode(1'b1);
    random_phase(RANDOM_PER_PHASE, 0, 0);
    drain_and_settle();
  endtask

  // Ends the run when no transfer happens for too long
  task automatic watch_progress();
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    timed_out = 1'b1;
    $display("watchdog: no transfer in %0d cycles, %0d bus words still expected",
             QUIET_LIMIT, outstanding);
  endtask

  initial begin
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = 1'b0;
    steady           = 1'b0;
    timed_out        = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.kind      = KIND_INIT;
    req_ch.row       = 8'd0;
    req_ch.column    = 8'd0;
    req_ch.character = 8'h00;
    req_ch.int_value = 32'sd0;
    res_ch.ready     = 1'b0;
    fork
      run_stimulus();
      watch_progress();
    join_any
    $display("Covered %0d requests (%0d driving the bus), %0d bus width writes, 4-bit and 8-bit.",
             requests_sent, productive_sent, mode_writes);
    $display("Checked %0d bus words: %0d mismatches, %0d still expected.",
             words_checked, mismatches, outstanding);
    if (!timed_out && mismatches == 0 && outstanding == 0)
      $display("** char_lcd_write_sequencer: PASSED **");
    else
      $display("** char_lcd_write_sequencer: FAILED **");
    $finish;
  end

endmodule

// File: char_lcd_write_sequencer.f
+incdir+rtl
rtl/clsq_pkg.sv
rtl/clsq_ifs.sv
rtl/clsq_dec.sv
rtl/clsq_useq.sv
rtl/char_lcd_write_sequencer.sv
test/lcd_bus_checker.sv
test/tb_top.sv
